[sv/bplt_pkg.sv]
`timescale 1ns / 1ps

package bplt_pkg;

    localparam int DEB_W   = 10;
    localparam int POLL_W  = 8;
    localparam int LONG_W  = 16;
    localparam int LED_W   = 20;
    localparam int CNT_W   = 10;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 20;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 10'd50;
    localparam logic [POLL_W-1:0] POLL_RESET     = 8'd10;
    localparam logic [LONG_W-1:0] LONG_RESET     = 16'd2000;
    localparam logic [LED_W-1:0]  LED_ON_RESET   = 20'd10000;

    typedef enum logic [INDEX_W-1:0] {
        REG_DEBOUNCE = 4'd0,
        REG_POLL     = 4'd1,
        REG_LONG     = 4'd2,
        REG_LED_ON   = 4'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_TIMING   = 2'd2,
        PH_RELEASE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [POLL_W-1:0] poll_ticks;
        logic [LONG_W-1:0] long_press_ticks;
        logic [LED_W-1:0]  led_on_ticks;
    } cfg_t;

    typedef struct packed {
        logic   led;
        event_t press_event;
        logic   busy;
    } res_t;

endpackage

[sv/bplt_cfg.sv]
`timescale 1ns / 1ps

module bplt_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bplt_pkg::INDEX_W-1:0]     cfg_index,
    input  logic [bplt_pkg::DATA_W-1:0]      cfg_data,
    output bplt_pkg::cfg_t                   cfg
);

    bplt_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= bplt_pkg::DEBOUNCE_RESET;
            cfg_reg.poll_ticks       <= bplt_pkg::POLL_RESET;
            cfg_reg.long_press_ticks <= bplt_pkg::LONG_RESET;
            cfg_reg.led_on_ticks     <= bplt_pkg::LED_ON_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // unknown indexes are dropped
            case (cfg_index)
                bplt_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ticks <= cfg_data[bplt_pkg::DEB_W-1:0];
                bplt_pkg::REG_POLL:
                    cfg_reg.poll_ticks <= cfg_data[bplt_pkg::POLL_W-1:0];
                bplt_pkg::REG_LONG:
                    cfg_reg.long_press_ticks <= cfg_data[bplt_pkg::LONG_W-1:0];
                bplt_pkg::REG_LED_ON:
                    cfg_reg.led_on_ticks <= cfg_data[bplt_pkg::LED_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

[sv/bplt_core.sv]
`timescale 1ns / 1ps

module bplt_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic           level,
    input  bplt_pkg::cfg_t cfg,
    output bplt_pkg::res_t res
);

    logic                          prev_level_reg;
    bplt_pkg::phase_t              phase_reg;
    logic [bplt_pkg::CNT_W-1:0]    cnt_reg;
    logic [bplt_pkg::LONG_W-1:0]   dur_reg;
    logic                          led_reg;
    logic [bplt_pkg::LED_W-1:0]    led_rem_reg;

    bplt_pkg::phase_t              phase_next;
    logic [bplt_pkg::CNT_W-1:0]    cnt_next;
    logic [bplt_pkg::LONG_W-1:0]   dur_next;
    logic                          led_next;
    logic [bplt_pkg::LED_W-1:0]    led_rem_next;
    bplt_pkg::event_t              event_next;

    logic [bplt_pkg::CNT_W-1:0]    cnt_inc;
    logic [bplt_pkg::CNT_W-1:0]    wait_len;
    logic                          wait_done;
    logic [bplt_pkg::LONG_W:0]     dur_sum;
    logic [bplt_pkg::LONG_W-1:0]   dur_sat;

    assign cnt_inc  = cnt_reg + 10'd1;
    assign wait_len = (phase_reg == bplt_pkg::PH_DEBOUNCE) ? cfg.debounce_ticks
                    : {2'b00, cfg.poll_ticks};
    // zero length behaves as one tick since cnt_inc is never zero here
    assign wait_done = (cnt_inc >= wait_len);
    assign dur_sum   = {1'b0, dur_reg} + {9'b0, cfg.poll_ticks};
    assign dur_sat   = dur_sum[bplt_pkg::LONG_W] ? '1 : dur_sum[bplt_pkg::LONG_W-1:0];

    always_comb
    begin
        led_rem_next = led_rem_reg;
        led_next     = led_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        dur_next     = dur_reg;
        event_next   = bplt_pkg::EV_NONE;

        // one-shot led timer runs ahead of the phase logic
        if (led_rem_reg != '0)
        begin
            led_rem_next = led_rem_reg - 20'd1;
            if (led_rem_next == '0)
            begin
                led_next = 1'b0;
            end
        end

        case (phase_reg)
            bplt_pkg::PH_IDLE:
            begin
                if (prev_level_reg && !level)
                begin
                    phase_next = bplt_pkg::PH_DEBOUNCE;
                    cnt_next   = '0;
                end
            end
            bplt_pkg::PH_DEBOUNCE:
            begin
                cnt_next = wait_done ? '0 : cnt_inc;
                if (wait_done)
                begin
                    if (!level)
                    begin
                        phase_next = bplt_pkg::PH_TIMING;
                        dur_next   = '0;
                    end
                    else
                    begin
                        phase_next = bplt_pkg::PH_IDLE;
                    end
                end
            end
            bplt_pkg::PH_TIMING:
            begin
                cnt_next = wait_done ? '0 : cnt_inc;
                if (wait_done)
                begin
                    dur_next = dur_sat;
                    if (dur_sat >= cfg.long_press_ticks)
                    begin
                        event_next   = bplt_pkg::EV_LONG;
                        led_next     = 1'b0;
                        led_rem_next = '0;
                        phase_next   = level ? bplt_pkg::PH_IDLE : bplt_pkg::PH_RELEASE;
                    end
                    else if (level)
                    begin
                        event_next   = bplt_pkg::EV_SHORT;
                        led_next     = 1'b1;
                        led_rem_next = cfg.led_on_ticks;
                        phase_next   = bplt_pkg::PH_IDLE;
                    end
                end
            end
            bplt_pkg::PH_RELEASE:
            begin
                cnt_next = wait_done ? '0 : cnt_inc;
                if (wait_done && level)
                begin
                    phase_next = bplt_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = bplt_pkg::PH_IDLE;
            end
        endcase

        res.led         = led_next;
        res.press_event = event_next;
        res.busy        = (phase_next != bplt_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            phase_reg      <= bplt_pkg::PH_IDLE;
            cnt_reg        <= '0;
            dur_reg        <= '0;
            led_reg        <= 1'b0;
            led_rem_reg    <= '0;
        end
        else if (fire)
        begin
            prev_level_reg <= level;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            dur_reg        <= dur_next;
            led_reg        <= led_next;
            led_rem_reg    <= led_rem_next;
        end
    end

    a_event_from_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.press_event != bplt_pkg::EV_NONE) |-> (phase_reg == bplt_pkg::PH_TIMING))
        else $error("press classified outside timing phase");

    a_short_lights_led: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.press_event == bplt_pkg::EV_SHORT) |=> (led_reg && led_rem_reg == cfg.led_on_ticks))
        else $error("short press did not arm led timer");

    a_long_kills_led: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.press_event == bplt_pkg::EV_LONG) |=> (!led_reg && led_rem_reg == '0))
        else $error("long press left led running");

    // a short press on the expiry tick relights the led
    a_timer_off_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && led_rem_reg == 20'd1 && res.press_event != bplt_pkg::EV_SHORT) |=> !led_reg)
        else $error("led still lit after timer expiry");

endmodule

[sv/button_press_classifier_led_timer.sv]
`timescale 1ns / 1ps

// button press classifier with one-shot led timer
// in channel: one beat per tick, button_level is the active-low button sample
// out channel: one beat per input beat, led_level, press_event and busy_res
//   describe the state after that tick
// cfg channel: cfg_index 0 debounce, 1 poll, 2 long threshold, 3 led on time;
//   always ready, write only while no tick is in flight
// path: a beat is captured in the input register, passes the tick step and is
//   written to the result register, from which it is offered
// throughput: one beat per cycle unless the receiver stalls; the tick step is
//   a single pass of logic between the input register and the result register
// receiver stall: the result register holds, the input register takes one more
//   beat if it is empty, then in_ready drops until out_ready returns
// reset: both registers empty, led off, phase idle, button taken as released,
//   config registers back to 50 / 10 / 2000 / 10000
module button_press_classifier_led_timer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          button_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          led_level,
    output logic [1:0]                    press_event,
    output logic                          busy_res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bplt_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [bplt_pkg::DATA_W-1:0]   cfg_data
);

    bplt_pkg::cfg_t cfg;
    bplt_pkg::res_t res;
    bplt_pkg::res_t out_res_reg;

    logic in_full_reg;
    logic in_level_reg;
    logic out_full_reg;
    logic advance;

    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    bplt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bplt_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .level (in_level_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_level_reg <= button_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_full_reg;
    assign led_level   = out_res_reg.led;
    assign press_event = out_res_reg.press_event;
    assign busy_res    = out_res_reg.busy;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !out_ready) |-> !advance)
        else $error("result register overwritten while stalled");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !advance) |=> in_full_reg)
        else $error("pending beat lost");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> in_ready)
        else $error("input stalled with empty input register");

endmodule
